### rtl/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int NEED_W = 2;
    localparam int LEN_W  = 3;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // continuation bytes still expected after a lead
    localparam logic [NEED_W-1:0] NEED_NONE  = 2'd0;
    localparam logic [NEED_W-1:0] NEED_ONE   = 2'd1;
    localparam logic [NEED_W-1:0] NEED_TWO   = 2'd2;
    localparam logic [NEED_W-1:0] NEED_THREE = 2'd3;

    // pending sequence state
    typedef struct packed {
        logic [CP_W-1:0]   partial;
        logic [NEED_W-1:0] need;
        logic [LEN_W-1:0]  total;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_CLEAR = '{partial: '0, need: NEED_NONE, total: LEN_NONE};

    // one decoded result
    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code;
        logic [LEN_W-1:0] len;
    } dec_result_t;

endpackage

### rtl/utf8_lenient_decoder.sv
`timescale 1ns / 1ps

// Lenient UTF-8 decoder: bytes in, one code point per complete sequence out.
// Input channel: in_valid / in_stall carry in_byte and end_of_text, one byte
//   per beat. A zero byte or end_of_text drops any incomplete sequence.
// Output channel: out_valid / out_stall carry code_point and seq_length.
//   Bytes that complete no sequence (leads, continuations mid-sequence, stray
//   or invalid bytes) give no output beat.
// Registers: the accepting edge loads a byte into the input register, and its
//   result goes into the result register once that register is free to take it.
// Throughput: one byte per cycle; the decode between the two registers is a
//   single shallow pass, and the input register keeps taking bytes while a
//   result waits in the output register as long as that register drains.
// Stall: when out_stall holds a waiting result, the byte in the input
//   register waits too and in_stall rises; nothing is lost or repeated.
// Reset: rst_n clears the valid flags of both registers and the pending
//   sequence; the block can take a byte straight out of reset.
module utf8_lenient_decoder
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_text,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CP_W-1:0]   code_point,
    output logic [LEN_W-1:0]  seq_length
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_eot_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_result_t       res;
    logic              out_valid_reg;
    logic [CP_W-1:0]   code_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              out_free;
    logic              s1_fire;
    logic              in_fire;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    utf8d_step u_step (
        .in_byte     (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (res)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= in_byte;
            s1_eot_reg  <= end_of_text;
        end
    end

    // pending sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DEC_STATE_CLEAR;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && res.valid;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && res.valid)
        begin
            code_reg <= res.code;
            len_reg  <= res.len;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_reg;
    assign seq_length = len_reg;

endmodule

### rtl/utf8d_step.sv
`timescale 1ns / 1ps

module utf8d_step
    import utf8d_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_text,
    input  dec_state_t        cur,
    output dec_state_t        nxt,
    output dec_result_t       res
);

    logic is_cont;
    logic [CP_W-1:0] shifted;

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign shifted = {cur.partial[CP_W-7:0], in_byte[5:0]};

    // decode one byte against the pending sequence
    always_comb
    begin
        nxt = cur;
        res = '{valid: 1'b0, code: '0, len: LEN_NONE};
        if (in_byte == '0)
        begin
            nxt = DEC_STATE_CLEAR;
        end
        else if (is_cont)
        begin
            // stray continuation with nothing pending is dropped
            if (cur.need != NEED_NONE)
            begin
                nxt.partial = shifted;
                nxt.need    = cur.need - NEED_ONE;
                if (cur.need == NEED_ONE)
                begin
                    res = '{valid: 1'b1, code: shifted, len: cur.total};
                    nxt = DEC_STATE_CLEAR;
                end
            end
        end
        else
        begin
            // fresh lead byte, any pending bytes are discarded
            nxt = DEC_STATE_CLEAR;
            if (in_byte[7] == 1'b0)
            begin
                res = '{valid: 1'b1, code: {{(CP_W-BYTE_W){1'b0}}, in_byte}, len: LEN_ONE};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                nxt = '{partial: {{(CP_W-5){1'b0}}, in_byte[4:0]}, need: NEED_ONE,
                        total: LEN_TWO};
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                nxt = '{partial: {{(CP_W-4){1'b0}}, in_byte[3:0]}, need: NEED_TWO,
                        total: LEN_THREE};
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                nxt = '{partial: {{(CP_W-3){1'b0}}, in_byte[2:0]}, need: NEED_THREE,
                        total: LEN_FOUR};
            end
        end
        // end of text drops whatever is still incomplete
        if (end_of_text)
        begin
            nxt = DEC_STATE_CLEAR;
        end
    end

endmodule

### rtl/utf8d_checker.sv
`timescale 1ns / 1ps

module utf8d_checker
    import utf8d_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CP_W-1:0]   code_point,
    input logic [LEN_W-1:0]  seq_length
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(seq_length))
        else $error("stalled output beat changed");

    // input backpressure only comes from a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // sequence length is one to four
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seq_length == LEN_ONE || seq_length == LEN_TWO ||
                      seq_length == LEN_THREE || seq_length == LEN_FOUR)
        else $error("bad sequence length");

    // code point fits the payload bits of its sequence length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (seq_length != LEN_ONE || code_point < 21'h80) &&
                      (seq_length != LEN_TWO || code_point < 21'h800) &&
                      (seq_length != LEN_THREE || code_point < 21'h10000))
        else $error("code point too wide for its length");

    // a single byte result is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seq_length == LEN_ONE |-> code_point != '0)
        else $error("zero byte decoded");

endmodule

bind utf8_lenient_decoder utf8d_checker u_utf8d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .seq_length (seq_length)
);
